@@ hdl/sdf_pkg.sv @@
// shared types, constants and the sine sample function for the smearing factor block
// no dependencies; imported by sdf_cfg, sdf_sinc and smearing_decorrelation_factor_top
package sdf_pkg;

	// field widths
	localparam int unsigned FREQ_W     = 35;
	localparam int unsigned UVW_W      = 34;
	localparam int unsigned RATE_W     = 27;
	localparam int unsigned FACTOR_W   = 18;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DIR_W      = 28;
	localparam int unsigned X_W        = 49;
	localparam int unsigned GAIN_W     = 63;

	// table resolution default
	localparam int unsigned SINC_TABLE_BITS_DEF = 10;

	// fixed point constants
	localparam logic [17:0] ONE_Q16       = 18'd65536;
	localparam logic [31:0] PI_Q30        = 32'd3373259426;
	localparam logic [21:0] PI_Q20        = 22'd3294199;
	localparam logic [30:0] RECIP_C_MM    = 31'd1969014879;
	localparam logic [28:0] RECIP_C_M     = 29'd480716523;
	localparam logic [X_W-1:0] X_CAP      = X_W'(64'd1 << 48);

	// latency figures
	localparam int unsigned FRONT_LAT  = 7;
	localparam int unsigned SINC_LAT   = 22;
	localparam int unsigned PIPE_DEPTH = FRONT_LAT + SINC_LAT;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE     = 3'd0,
		REG_FREQ_ON    = 3'd1,
		REG_TIME_ON    = 3'd2,
		REG_OFFSET_L   = 3'd3,
		REG_OFFSET_M   = 3'd4,
		REG_TIME_STEP  = 3'd5,
		REG_CHAN_WIDTH = 3'd6
	} sdf_reg_t;

	// configuration sequencer states
	typedef enum logic [2:0] {
		CFG_IDLE,
		CFG_SQR,
		CFG_ARG,
		CFG_ROOT,
		CFG_FIN
	} sdf_cfg_state_t;

	// settled configuration handed to the datapath
	typedef struct packed {
		logic                     enable;
		logic                     freq_on;
		logic                     time_on;
		logic signed [DIR_W-1:0]  l26;
		logic signed [DIR_W-1:0]  m26;
		logic signed [DIR_W-1:0]  n26;
		logic [31:0]              time_step;
		logic [GAIN_W-1:0]        gain;
		logic                     busy;
	} sdf_cfg_t;

	// Q2.30 to Q.26, truncated toward zero
	function automatic logic signed [DIR_W-1:0] div16(input logic signed [31:0] v);
		logic signed [32:0] t;
		t = {v[31], v} + (v[31] ? 33'sd15 : 33'sd0);
		return t[31:4];
	endfunction

	// sin(pi*i/2^tb) in Q.30, taylor series by horner with truncation
	function automatic logic [30:0] sine_sample(input int unsigned i, input int unsigned tb);
		longint unsigned one;
		longint unsigned y;
		longint unsigned y2;
		longint unsigned acc;
		longint unsigned r;
		one = 64'd1 << 30;
		y   = (longint'(i) * longint'(PI_Q30)) >> tb;
		y2  = (y * y) >> 30;
		acc = one;
		acc = one - (((y2 * acc) >> 30) / 64'd156);
		acc = one - (((y2 * acc) >> 30) / 64'd110);
		acc = one - (((y2 * acc) >> 30) / 64'd72);
		acc = one - (((y2 * acc) >> 30) / 64'd42);
		acc = one - (((y2 * acc) >> 30) / 64'd20);
		acc = one - (((y2 * acc) >> 30) / 64'd6);
		r   = (y * acc) >> 30;
		return r[30:0];
	endfunction

endpackage

@@ hdl/sdf_cfg.sv @@
// configuration registers and the derived direction and gain values
// depends on sdf_pkg; computes n from l and m with a bit-serial square root
module sdf_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sdf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sdf_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sdf_pkg::sdf_cfg_t               cfg
);
	import sdf_pkg::*;

	sdf_cfg_state_t state_q, state_nxt;

	logic                    enable_q, freq_on_q, time_on_q;
	logic signed [31:0]      l_q, m_q;
	logic [31:0]             ts_q, chw_q;
	logic [62:0]             lsq_q, msq_q;
	logic [63:0]             x_q, r_q, bit_q;
	logic [4:0]              cnt_q;
	logic signed [DIR_W-1:0] l26_q, m26_q, n26_q;
	logic [GAIN_W-1:0]       gain_q;

	logic signed [63:0] lsq_full, msq_full;
	logic [63:0]        sq_sum, trial;
	logic signed [31:0] n_full;

	assign lsq_full = l_q * l_q;
	assign msq_full = m_q * m_q;
	assign sq_sum   = {1'b0, lsq_q} + {1'b0, msq_q};
	assign trial    = r_q + bit_q;
	assign n_full   = $signed({1'b0, r_q[30:0]}) - 32'sd1073741824;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CFG_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			CFG_IDLE: if (cfg_we) state_nxt = CFG_SQR;
			CFG_SQR:  state_nxt = CFG_ARG;
			CFG_ARG:  state_nxt = CFG_ROOT;
			CFG_ROOT: if (cnt_q == 5'd31) state_nxt = CFG_FIN;
			CFG_FIN:  state_nxt = CFG_IDLE;
			default:  state_nxt = CFG_IDLE;
		endcase
		// a later write restarts the pass with the newest values
		if (cfg_we) state_nxt = CFG_SQR;
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			freq_on_q <= 1'b0;
			time_on_q <= 1'b0;
			l_q       <= '0;
			m_q       <= '0;
			ts_q      <= '0;
			chw_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:     enable_q  <= cfg_data[0];
				REG_FREQ_ON:    freq_on_q <= cfg_data[0];
				REG_TIME_ON:    time_on_q <= cfg_data[0];
				REG_OFFSET_L:   l_q       <= cfg_data;
				REG_OFFSET_M:   m_q       <= cfg_data;
				REG_TIME_STEP:  ts_q      <= cfg_data;
				REG_CHAN_WIDTH: chw_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// derived values, one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsq_q  <= '0;
			msq_q  <= '0;
			x_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			l26_q  <= '0;
			m26_q  <= '0;
			n26_q  <= '0;
			gain_q <= '0;
		end else begin
			unique case (state_q)
				CFG_IDLE: begin
				end
				CFG_SQR: begin
					lsq_q <= lsq_full[62:0];
					msq_q <= msq_full[62:0];
				end
				CFG_ARG: begin
					x_q   <= (sq_sum < (64'd1 << 60)) ? (64'd1 << 60) - sq_sum : 64'd0;
					r_q   <= '0;
					bit_q <= 64'd1 << 62;
					cnt_q <= '0;
				end
				CFG_ROOT: begin
					if (x_q >= trial) begin
						x_q <= x_q - trial;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
				end
				CFG_FIN: begin
					n26_q  <= div16(n_full);
					l26_q  <= div16(l_q);
					m26_q  <= div16(m_q);
					gain_q <= chw_q * RECIP_C_MM;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.enable    = enable_q;
	assign cfg.freq_on   = freq_on_q;
	assign cfg.time_on   = time_on_q;
	assign cfg.l26       = l26_q;
	assign cfg.m26       = m26_q;
	assign cfg.n26       = n26_q;
	assign cfg.time_step = ts_q;
	assign cfg.gain      = gain_q;
	assign cfg.busy      = cfg_we || (state_q != CFG_IDLE);

endmodule

@@ hdl/sdf_sinc.sv @@
// pipelined sinc of a Q.32 argument: table interpolation and restoring divide
// depends on sdf_pkg; the pipeline advances only on en
module sdf_sinc #(
	parameter int unsigned SINC_TABLE_BITS = sdf_pkg::SINC_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [sdf_pkg::X_W-1:0]             a,
	output logic signed [sdf_pkg::FACTOR_W-1:0] term
);
	import sdf_pkg::*;

	localparam int unsigned TB    = SINC_TABLE_BITS;
	localparam int unsigned FS    = 32 - TB;
	localparam int unsigned FULL  = 1 << TB;
	localparam int unsigned HALF  = FULL >> 1;
	localparam int unsigned DN_W  = 42;
	localparam int unsigned NUM_W = 44;
	localparam int unsigned CMP_W = 60;
	localparam int unsigned DIV_N = 17;

	typedef struct packed {
		logic near_zero;
		logic capped;
		logic odd;
	} flags_t;

	// folded quarter-wave sample table
	logic [30:0] sine_tab [HALF+1];
	for (genvar gi = 0; gi <= HALF; gi++) begin : g_tab
		assign sine_tab[gi] = sine_sample(gi, TB);
	end

	logic [TB-1:0] i0, j0, j1;
	logic [TB:0]   i1;
	logic [61:0]   dn_full;
	flags_t        flg_in;

	assign i0 = a[31:FS];
	assign i1 = {1'b0, i0} + (TB+1)'(1);
	assign j0 = ({1'b0, i0} <= (TB+1)'(HALF)) ? i0 : (TB)'((TB+1)'(FULL) - {1'b0, i0});
	assign j1 = (i1 <= (TB+1)'(HALF)) ? i1[TB-1:0] : (TB)'((TB+1)'(FULL) - i1);
	assign dn_full = a[47:8] * PI_Q20;
	assign flg_in.near_zero = (a[X_W-1:22] == '0);
	assign flg_in.capped    = a[X_W-1];
	assign flg_in.odd       = a[32];

	// stage 1: table reads and denominator
	logic [30:0]     samp0_s1, samp1_s1;
	logic [FS-1:0]   frac_s1;
	logic [DN_W-1:0] dn_s1;
	flags_t          flg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			samp0_s1 <= sine_tab[j0];
			samp1_s1 <= sine_tab[j1];
			frac_s1  <= a[FS-1:0];
			dn_s1    <= dn_full[61:20];
			flg_s1   <= flg_in;
		end
	end

	// stage 2: interpolation products
	logic [FS:0]     wr;
	logic [FS+31:0]  prod0_s2;
	logic [FS+30:0]  prod1_s2;
	logic [DN_W-1:0] dn_s2;
	flags_t          flg_s2;

	assign wr = (FS+1)'(1 << FS) - {1'b0, frac_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			prod0_s2 <= samp0_s1 * wr;
			prod1_s2 <= samp1_s1 * frac_s1;
			dn_s2    <= dn_s1;
			flg_s2   <= flg_s1;
		end
	end

	// stage 3: interpolated sine
	logic [FS+32:0]  isum;
	logic [30:0]     sint_s3;
	logic [DN_W-1:0] dn_s3;
	flags_t          flg_s3;

	assign isum = (FS+33)'(prod0_s2) + (FS+33)'(prod1_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			sint_s3 <= isum[FS+30:FS];
			dn_s3   <= dn_s2;
			flg_s3  <= flg_s2;
		end
	end

	// stage 4: rounded dividend and early clamp
	logic [NUM_W-1:0] num;
	assign num = NUM_W'({sint_s3, 10'b0}) + NUM_W'(dn_s3 >> 1);

	logic [NUM_W-1:0] rem_s  [DIV_N+1];
	logic [DIV_N-1:0] quo_s  [DIV_N+1];
	logic [DN_W-1:0]  dnp_s  [DIV_N+1];
	flags_t           flg_d  [DIV_N+1];
	logic             clmp_d [DIV_N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			quo_s[0]  <= '0;
			dnp_s[0]  <= dn_s3;
			flg_d[0]  <= flg_s3;
			clmp_d[0] <= CMP_W'(num) >= (CMP_W'(dn_s3) << DIV_N);
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		localparam int unsigned J = DIV_N - 1 - k;
		logic [CMP_W-1:0] dsh;
		logic             ge;
		assign dsh = CMP_W'(dnp_s[k]) << J;
		assign ge  = CMP_W'(rem_s[k]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? NUM_W'(CMP_W'(rem_s[k]) - dsh) : rem_s[k];
				quo_s[k+1]  <= quo_s[k] | (ge ? DIV_N'(1 << J) : '0);
				dnp_s[k+1]  <= dnp_s[k];
				flg_d[k+1]  <= flg_d[k];
				clmp_d[k+1] <= clmp_d[k];
			end
		end
	end

	// final stage: clamp, sign and special cases
	logic [FACTOR_W-1:0] mag;
	flags_t              flg_f;
	assign flg_f = flg_d[DIV_N];
	assign mag   = (clmp_d[DIV_N] || ({1'b0, quo_s[DIV_N]} > ONE_Q16)) ? ONE_Q16
	             : {1'b0, quo_s[DIV_N]};

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (flg_f.near_zero) begin
				term <= $signed(ONE_Q16);
			end else if (flg_f.capped) begin
				term <= '0;
			end else if (flg_f.odd) begin
				term <= -$signed(mag);
			end else begin
				term <= $signed(mag);
			end
		end
	end

endmodule

@@ hdl/smearing_decorrelation_factor_top.sv @@
// top level of the visibility smearing decorrelation factor block
// depends on sdf_pkg, sdf_cfg and sdf_sinc
//
// One factor per visibility sample, one sample per clock when the output side keeps up and no
// configuration write or pass is under way. 7 stages form the two sinc arguments (direction
// products, sums, magnitudes, split wide multiplies) and 22 stages evaluate both sinc terms
// side by side, 17 of them a one-bit-per-stage divider; the last register combines the terms.
// The whole pipeline holds while the output register is full and stalled. Any configuration
// write starts a pass that recomputes n from l and m with a bit-serial square root and the
// bandwidth gain; input is stalled during the write and that pass. The user must write
// configuration only while no sample is in flight; the block itself does not enforce this.
module smearing_decorrelation_factor_top #(
	parameter int unsigned SINC_TABLE_BITS = sdf_pkg::SINC_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [sdf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sdf_pkg::CFG_DATA_W-1:0]        cfg_data,
	// sample input
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [sdf_pkg::FREQ_W-1:0]            freq_hz,
	input  logic signed [sdf_pkg::UVW_W-1:0]      u_mm,
	input  logic signed [sdf_pkg::UVW_W-1:0]      v_mm,
	input  logic signed [sdf_pkg::UVW_W-1:0]      w_mm,
	input  logic signed [sdf_pkg::RATE_W-1:0]     du_rate,
	input  logic signed [sdf_pkg::RATE_W-1:0]     dv_rate,
	input  logic signed [sdf_pkg::RATE_W-1:0]     dw_rate,
	// factor output
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sdf_pkg::FACTOR_W-1:0]   decorr_factor
);
	import sdf_pkg::*;

	sdf_cfg_t cfg;

	sdf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline moves unless the output register holds a stalled factor
	logic adv, accept;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv || cfg.busy;
	assign accept   = in_valid && !in_stall;

	// valid bit for each stage
	logic [PIPE_DEPTH:1] vld_s;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], accept};
		end
	end

	// stage 1: direction products, u*l etc and du*l etc, plus freq over c
	logic signed [61:0] pu_s1, pv_s1, pw_s1;
	logic signed [54:0] qu_s1, qv_s1, qw_s1;
	logic [63:0]        h_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s1 <= u_mm * cfg.l26;
			pv_s1 <= v_mm * cfg.m26;
			pw_s1 <= w_mm * cfg.n26;
			qu_s1 <= du_rate * cfg.l26;
			qv_s1 <= dv_rate * cfg.m26;
			qw_s1 <= dw_rate * cfg.n26;
			h_s1  <= freq_hz * RECIP_C_M;
		end
	end

	// stage 2: dot products
	logic signed [63:0] p_s2;
	logic signed [56:0] q_s2;
	logic [63:0]        h_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2 <= 64'(pu_s1) + 64'(pv_s1) + 64'(pw_s1);
			q_s2 <= 57'(qu_s1) + 57'(qv_s1) + 57'(qw_s1);
			h_s2 <= h_s1;
		end
	end

	// stage 3: magnitudes
	logic signed [63:0] p_neg;
	logic signed [56:0] q_neg;
	logic [61:0]        pa_s3;
	logic [54:0]        qa_s3;
	logic [63:0]        h_s3;

	assign p_neg = -p_s2;
	assign q_neg = -q_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s3 <= p_s2[63] ? p_neg[61:0] : p_s2[61:0];
			qa_s3 <= q_s2[56] ? q_neg[54:0] : q_s2[54:0];
			h_s3  <= h_s2;
		end
	end

	// stage 4: gain*|P| partial products, |Q|*time_step halves
	logic [63:0] bb00_s4;
	logic [61:0] bb01_s4;
	logic [62:0] bb10_s4;
	logic [60:0] bb11_s4;
	logic [63:0] tlo_s4;
	logic [54:0] thi_s4;
	logic [63:0] h_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			bb00_s4 <= cfg.gain[31:0] * pa_s3[31:0];
			bb01_s4 <= cfg.gain[31:0] * pa_s3[61:32];
			bb10_s4 <= cfg.gain[62:32] * pa_s3[31:0];
			bb11_s4 <= cfg.gain[62:32] * pa_s3[61:32];
			tlo_s4  <= qa_s3[31:0] * cfg.time_step;
			thi_s4  <= qa_s3[54:32] * cfg.time_step;
			h_s4    <= h_s3;
		end
	end

	// stage 5: bandwidth argument, saturated; time path distance in metres
	logic [124:0] pf;
	logic [61:0]  rf;
	logic [X_W-1:0] xf_s5;
	logic [54:0]  d_s5;
	logic [63:0]  h_s5;

	assign pf = 125'(bb00_s4) + (125'(bb01_s4) << 32) + (125'(bb10_s4) << 32)
	          + (125'(bb11_s4) << 64);
	assign rf = pf[124:63];

	always_ff @(posedge clk) begin
		if (adv) begin
			xf_s5 <= (rf >= 62'(X_CAP)) ? X_CAP : rf[X_W-1:0];
			d_s5  <= 55'(thi_s4) + 55'(tlo_s4[63:32]);
			h_s5  <= h_s4;
		end
	end

	// stage 6: h*d partial products
	logic [63:0]    hd00_s6, hd10_s6;
	logic [54:0]    hd01_s6, hd11_s6;
	logic [X_W-1:0] xf_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			hd00_s6 <= h_s5[31:0] * d_s5[31:0];
			hd01_s6 <= h_s5[31:0] * d_s5[54:32];
			hd10_s6 <= h_s5[63:32] * d_s5[31:0];
			hd11_s6 <= h_s5[63:32] * d_s5[54:32];
			xf_s6   <= xf_s5;
		end
	end

	// stage 7: time argument, saturated
	logic [118:0]   pt;
	logic [67:0]    rt;
	logic [X_W-1:0] xt_s7, xf_s7;

	assign pt = 119'(hd00_s6) + (119'(hd01_s6) << 32) + (119'(hd10_s6) << 32)
	          + (119'(hd11_s6) << 64);
	assign rt = pt[118:51];

	always_ff @(posedge clk) begin
		if (adv) begin
			xt_s7 <= (rt >= 68'(X_CAP)) ? X_CAP : rt[X_W-1:0];
			xf_s7 <= xf_s6;
		end
	end

	// both sinc terms in parallel
	logic signed [FACTOR_W-1:0] term_f, term_t;

	sdf_sinc #(.SINC_TABLE_BITS(SINC_TABLE_BITS)) u_sinc_freq (
		.clk  (clk),
		.en   (adv),
		.a    (xf_s7),
		.term (term_f)
	);

	sdf_sinc #(.SINC_TABLE_BITS(SINC_TABLE_BITS)) u_sinc_time (
		.clk  (clk),
		.en   (adv),
		.a    (xt_s7),
		.term (term_t)
	);

	// combine terms as sign and magnitude with rounding
	logic [FACTOR_W-2:0]        mag_f, mag_t;
	logic [33:0]                mprod;
	logic [FACTOR_W-1:0]        mboth;
	logic signed [FACTOR_W-1:0] both, result;

	assign mag_f = term_f[FACTOR_W-1] ? (FACTOR_W-1)'(-term_f) : term_f[FACTOR_W-2:0];
	assign mag_t = term_t[FACTOR_W-1] ? (FACTOR_W-1)'(-term_t) : term_t[FACTOR_W-2:0];
	assign mprod = mag_f * mag_t + 34'd32768;
	assign mboth = mprod[33:16];
	assign both  = (term_f[FACTOR_W-1] ^ term_t[FACTOR_W-1]) ? -$signed(mboth)
	             : $signed(mboth);

	always_comb begin
		priority if (!cfg.enable) begin
			result = $signed(ONE_Q16);
		end else if (cfg.freq_on && cfg.time_on) begin
			result = both;
		end else if (cfg.freq_on) begin
			result = term_f;
		end else if (cfg.time_on) begin
			result = term_t;
		end else begin
			result = $signed(ONE_Q16);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s[PIPE_DEPTH];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			decorr_factor <= result;
		end
	end

endmodule

@@ tb/smearing_decorrelation_factor_top_tb.sv @@
// self-checking testbench for smearing_decorrelation_factor_top: random and directed samples,
// results predicted in-bench and compared in order; depends on sdf_pkg and the block's rtl
`timescale 1ns / 100ps

module smearing_decorrelation_factor_top_tb;
	import sdf_pkg::*;

	localparam int unsigned TBL_BITS = SINC_TABLE_BITS_DEF;
	// index that maps to no register, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam longint unsigned ARG_CAP   = 64'd1 << 48;
	localparam longint unsigned ARG_SMALL = 64'd1 << 22;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// one visibility sample
	typedef struct {
		logic [FREQ_W-1:0]         freq;
		logic signed [UVW_W-1:0]   u;
		logic signed [UVW_W-1:0]   v;
		logic signed [UVW_W-1:0]   w;
		logic signed [RATE_W-1:0]  du;
		logic signed [RATE_W-1:0]  dv;
		logic signed [RATE_W-1:0]  dw;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FREQ_W-1:0] freq_hz = '0;
	logic signed [UVW_W-1:0] u_mm = '0, v_mm = '0, w_mm = '0;
	logic signed [RATE_W-1:0] du_rate = '0, dv_rate = '0, dw_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [FACTOR_W-1:0] decorr_factor;

	// shadow copy of the register file
	logic        sh_enable, sh_freq_on, sh_time_on;
	logic [31:0] sh_off_l, sh_off_m, sh_tstep, sh_chan_w;

	logic [FACTOR_W-1:0] factor_q[$];
	int unsigned n_errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_smeared = 0;
	int unsigned cycles = 0;
	bit quiet = 1'b0;   // no idling on either side while set

	smearing_decorrelation_factor_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.freq_hz(freq_hz), .u_mm(u_mm), .v_mm(v_mm), .w_mm(w_mm),
		.du_rate(du_rate), .dv_rate(dv_rate), .dw_rate(dw_rate),
		.out_valid(out_valid), .out_stall(out_stall), .decorr_factor(decorr_factor)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// sin(pi*i/2^TBL_BITS) in q.30, folded into the first quarter period
	function automatic longint unsigned sine_q30(input longint unsigned i);
		longint unsigned divs[6] = '{156, 110, 72, 42, 20, 6};
		longint unsigned full, t, y, y2, acc;
		full = 64'd1 << TBL_BITS;
		t = (i <= full / 2) ? i : full - i;
		y = (t * 64'(PI_Q30)) >> TBL_BITS;
		y2 = (y * y) >> 30;
		acc = 64'd1 << 30;
		for (int k = 0; k < 6; k++)
			acc = (64'd1 << 30) - (((y2 * acc) >> 30) / divs[k]);
		return (y * acc) >> 30;
	endfunction

	// sinc of a q.32 argument, q1.16 signed
	function automatic longint sinc_q16(input longint unsigned a);
		int unsigned fs;
		longint unsigned wdt, f, idx, r, s, dn, mag;
		fs = 32 - TBL_BITS;
		wdt = 64'd1 << fs;
		if (a < ARG_SMALL) return 65536;
		if (a >= ARG_CAP) return 0;
		f = a & 64'hFFFF_FFFF;
		idx = f >> fs;
		r = f & (wdt - 1);
		s = (sine_q30(idx) * (wdt - r) + sine_q30(idx + 1) * r) >> fs;
		dn = ((a >> 8) * 64'(PI_Q20)) >> 20;
		mag = (s * 1024 + dn / 2) / dn;
		if (mag > 65536) mag = 65536;
		return a[32] ? -longint'(mag) : longint'(mag);
	endfunction

	// floor(a*b/2^s), saturated at the argument cap
	function automatic longint unsigned scaled_prod(input longint unsigned a,
			input longint unsigned b, input int unsigned s);
		logic [127:0] pr;
		pr = 128'(a) * 128'(b);
		pr = pr >> s;
		if (pr[127:64] != 0 || pr[63:0] > ARG_CAP) return ARG_CAP;
		return pr[63:0];
	endfunction

	function automatic longint apply_term(input longint p, input longint t);
		longint unsigned ap, at, m;
		ap = p < 0 ? -p : p;
		at = t < 0 ? -t : t;
		m = (ap * at + 32768) >> 16;
		return ((p < 0) != (t < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [FACTOR_W-1:0] predict_factor(input sample_t s);
		longint l, m, n, l26, m26, n26, p, q, res;
		longint unsigned sum, arg, g, h, d, ap, aq;
		logic [127:0] pr;
		res = 65536;
		if (sh_enable) begin
			l = longint'($signed(sh_off_l));
			m = longint'($signed(sh_off_m));
			sum = longint'(l * l) + longint'(m * m);
			arg = ((64'd1 << 60) > sum) ? (64'd1 << 60) - sum : 0;
			n = longint'(int_sqrt(arg)) - (64'sd1 << 30);
			l26 = l / 16;
			m26 = m / 16;
			n26 = n / 16;
			if (sh_freq_on) begin
				p = longint'(s.u) * l26 + longint'(s.v) * m26 + longint'(s.w) * n26;
				ap = p < 0 ? -p : p;
				g = 64'(sh_chan_w) * 64'(RECIP_C_MM);
				res = apply_term(res, sinc_q16(scaled_prod(g, ap, 63)));
			end
			if (sh_time_on) begin
				q = longint'(s.du) * l26 + longint'(s.dv) * m26 + longint'(s.dw) * n26;
				aq = q < 0 ? -q : q;
				pr = 128'(aq) * 128'(sh_tstep);
				d = pr[95:32];
				h = 64'(s.freq) * 64'(RECIP_C_M);
				res = apply_term(res, sinc_q16(scaled_prod(h, d, 51)));
			end
		end
		return res[FACTOR_W-1:0];
	endfunction

	// ---------------- checking and receiver stalls ----------------

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		n_errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (factor_q.size() == 0) begin
				report_mismatch($sformatf("unexpected factor %0d", decorr_factor));
			end else begin
				logic [FACTOR_W-1:0] want;
				want = factor_q.pop_front();
				if (decorr_factor !== want)
					report_mismatch($sformatf("decorr_factor got %0d want %0d",
						decorr_factor, $signed(want)));
				n_checked++;
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 19);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d factors outstanding", cycles, factor_q.size());
			$display("smearing_decorrelation_factor_top_tb: FAIL");
			$finish;
		end
	end

	// ---------------- stimulus helpers ----------------

	// register write, only issued while nothing is in flight; write enable stays up
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		in_valid  <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_ENABLE:     sh_enable  = data[0];
			REG_FREQ_ON:    sh_freq_on = data[0];
			REG_TIME_ON:    sh_time_on = data[0];
			REG_OFFSET_L:   sh_off_l   = data;
			REG_OFFSET_M:   sh_off_m   = data;
			REG_TIME_STEP:  sh_tstep   = data;
			REG_CHAN_WIDTH: sh_chan_w  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// close a run of register writes
	task automatic end_writes();
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic en, input logic fon, input logic ton,
			input logic [31:0] l, input logic [31:0] m, input logic [31:0] ts,
			input logic [31:0] cw);
		write_reg(REG_ENABLE, {31'd0, en});
		write_reg(REG_FREQ_ON, {31'd0, fon});
		write_reg(REG_TIME_ON, {31'd0, ton});
		write_reg(REG_OFFSET_L, l);
		write_reg(REG_OFFSET_M, m);
		write_reg(REG_TIME_STEP, ts);
		write_reg(REG_CHAN_WIDTH, cw);
		end_writes();
	endtask

	// wait until every factor has come back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (factor_q.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 8) @(posedge clk);
	endtask

	// one sample transfer; returns in the cycle of acceptance
	task automatic send_sample(input sample_t s);
		if (!quiet && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		freq_hz <= s.freq;
		u_mm    <= s.u;
		v_mm    <= s.v;
		w_mm    <= s.w;
		du_rate <= s.du;
		dv_rate <= s.dv;
		dw_rate <= s.dw;
		do @(posedge clk); while (in_stall);
		factor_q.push_back(predict_factor(s));
		n_sent++;
		if (sh_enable && (sh_freq_on || sh_time_on)) n_smeared++;
	endtask

	// value of random magnitude: short or full length, either sign
	function automatic logic [63:0] rnd_val(input int unsigned w);
		logic [63:0] v;
		int unsigned len;
		len = ($urandom_range(0, 3) == 0) ? w : $urandom_range(1, w);
		v = {$urandom, $urandom} >> (64 - len);
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	function automatic sample_t rnd_sample();
		sample_t s;
		s.freq = FREQ_W'(rnd_val(FREQ_W));
		s.u = UVW_W'(rnd_val(UVW_W));
		s.v = UVW_W'(rnd_val(UVW_W));
		s.w = UVW_W'(rnd_val(UVW_W));
		s.du = RATE_W'(rnd_val(RATE_W));
		s.dv = RATE_W'(rnd_val(RATE_W));
		s.dw = RATE_W'(rnd_val(RATE_W));
		return s;
	endfunction

	function automatic sample_t make_sample(input logic [FREQ_W-1:0] f,
			input logic signed [UVW_W-1:0] uvw, input logic signed [RATE_W-1:0] rate);
		sample_t s;
		s.freq = f;
		s.u = uvw;  s.v = uvw;  s.w = uvw;
		s.du = rate; s.dv = rate; s.dw = rate;
		return s;
	endfunction

	// direction cosine: mostly in range, sometimes anything
	function automatic logic [31:0] rnd_dir();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'(rnd_val(24));
			default: return 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
		endcase
	endfunction

	// ---------------- tests ----------------

	// block fresh out of reset: smearing disabled, factor must be exactly one
	task automatic test_reset_state();
		send_sample(make_sample('1, '1, '1));
		send_sample(make_sample('0, {1'b1, {(UVW_W-1){1'b0}}}, {1'b1, {(RATE_W-1){1'b0}}}));
		send_sample(rnd_sample());
		drain();
	endtask

	// directed corners: extremes, each term alone, clamp, ignored write
	task automatic test_corners();
		// enabled but both terms off
		write_all(1'b1, 1'b0, 1'b0, 32'h4000_0000, 32'h0, '1, '1);
		send_sample(make_sample('1, '1, '1));
		drain();
		// bandwidth term alone, zero argument and extremes
		write_all(1'b1, 1'b1, 1'b0, 32'h0000_8000, 32'hFFFF_9000, 32'h0, 32'd1000000);
		send_sample(make_sample('0, '0, '0));
		send_sample(make_sample('0, 34'sd1000, '0));
		send_sample(make_sample('0, 34'sd300000, '0));
		send_sample(make_sample('0, 34'sd8589934591, '0));
		send_sample(make_sample('0, -34'sd8589934592, '0));
		drain();
		// directions out of range take the sqrt clamp
		write_all(1'b1, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, '1, '1);
		send_sample(make_sample('1, 34'sd5, 27'sd3));
		send_sample(make_sample('1, '1, '1));
		drain();
		// time term alone, max step
		write_all(1'b1, 1'b0, 1'b1, 32'h0000_1000, 32'h0000_0800, '1, '0);
		send_sample(make_sample(35'd1400000000, '0, 27'sd100));
		send_sample(make_sample('1, '0, 27'sd67108863));
		send_sample(make_sample('1, '0, -27'sd67108864));
		send_sample(make_sample('0, '0, 27'sd12345));
		drain();
		// write to an unmapped index must change nothing
		write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
		end_writes();
		send_sample(make_sample(35'd700000000, '0, 27'sd4000));
		send_sample(make_sample(35'd123456789, 34'sd77, -27'sd99));
		drain();
		// boundary directions
		write_all(1'b1, 1'b1, 1'b1, 32'h4000_0000, 32'hC000_0000, 32'h0001_0000, 32'd250000);
		send_sample(make_sample(35'd1000000000, 34'sd40000, 27'sd65536));
		send_sample(rnd_sample());
		drain();
	endtask

	// random phase: new settings, then a burst of random samples
	task automatic test_random_phase(input int unsigned count, input bit pause_mid);
		logic [31:0] ts, cw;
		ts = ($urandom_range(0, 2) == 0) ? $urandom : 32'(rnd_val(20)) & 32'hF_FFFF;
		cw = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2000000);
		write_all($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), rnd_dir(), rnd_dir(), ts, cw);
		for (int i = 0; i < count; i++) begin
			send_sample(rnd_sample());
			// hold off until everything in flight has returned
			if (pause_mid && i == count / 2) begin
				in_valid <= 1'b0;
				while (factor_q.size() != 0) @(posedge clk);
			end
		end
		drain();
	endtask

	initial begin
		sh_enable = '0; sh_freq_on = '0; sh_time_on = '0;
		sh_off_l = '0; sh_off_m = '0; sh_tstep = '0; sh_chan_w = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_state();
		test_corners();
		test_random_phase(60, 1'b1);
		// long stretch with no idling on either side
		quiet = 1'b1;
		test_random_phase(80, 1'b0);
		quiet = 1'b0;
		for (int p = 0; p < 9; p++)
			test_random_phase(40, p == 4);

		$display("covered %0d samples over many register settings, %0d with smearing terms active",
			n_sent, n_smeared);
		$display("checked %0d factors, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && factor_q.size() == 0) begin
			$display("smearing_decorrelation_factor_top_tb: PASS");
		end else begin
			$display("smearing_decorrelation_factor_top_tb: FAIL");
		end
		$finish;
	end

endmodule
